// File: src/fust_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fust_pkg
// Shared types and constants of the first unique symbol tracker.
// ----------------------------------------------------------------------------
package fust_pkg;

    localparam int ALPHABET_SIZE_DEF = 26;
    localparam int SYM_W             = 5;

    // per-symbol occurrence status, saturating at repeated
    typedef enum logic [1:0] {
        ST_UNSEEN   = 2'd0,
        ST_ONCE     = 2'd1,
        ST_REPEATED = 2'd2
    } t_status;

    // list operation decided by the status table for one beat
    typedef struct packed {
        logic             append;
        logic             remove;
        logic [SYM_W-1:0] sym;
    } t_list_op;

endpackage

// File: src/fust_status.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fust_status
// Per-symbol status table; decides whether a beat appends or removes.
// ----------------------------------------------------------------------------
module fust_status
    import fust_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_restart,
    input  logic [SYM_W-1:0] i_letter,
    output t_list_op         o_op
);

    t_status                  r_status [ALPHABET_SIZE];
    t_status                  n_status [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] w_hit;
    t_status                  w_cur;

    // decode the letter; codes outside the alphabet hit nothing
    always_comb begin
        w_cur = ST_UNSEEN;
        for (int i = 0; i < ALPHABET_SIZE; i++) begin
            w_hit[i] = (int'(i_letter) == i);
            if (w_hit[i] && !i_restart) begin
                w_cur = r_status[i];
            end
        end
    end

    always_comb begin
        o_op.sym    = i_letter;
        o_op.append = (|w_hit) && (w_cur == ST_UNSEEN);
        o_op.remove = (|w_hit) && (w_cur == ST_ONCE);
    end

    always_comb begin
        for (int i = 0; i < ALPHABET_SIZE; i++) begin
            n_status[i] = i_restart ? ST_UNSEEN : r_status[i];
            if (w_hit[i]) begin
                unique case (n_status[i])
                    ST_UNSEEN:   n_status[i] = ST_ONCE;
                    ST_ONCE:     n_status[i] = ST_REPEATED;
                    ST_REPEATED: n_status[i] = ST_REPEATED;
                    default:     n_status[i] = ST_REPEATED;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ALPHABET_SIZE; i++) begin
            if (!i_rst_n) begin
                r_status[i] <= ST_UNSEEN;
            end else if (i_en) begin
                r_status[i] <= n_status[i];
            end
        end
    end

endmodule

// File: src/fust_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fust_cell
// One slot of the order list; appends, holds, or takes its right neighbor.
// ----------------------------------------------------------------------------
module fust_cell
    import fust_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_clear,
    input  t_list_op         i_op,
    input  logic             i_prev_valid,
    input  logic             i_shift_in,
    input  logic             i_next_valid,
    input  logic [SYM_W-1:0] i_next_sym,
    output logic             o_shift_out,
    output logic             o_valid,
    output logic [SYM_W-1:0] o_sym,
    output logic             o_n_valid,
    output logic [SYM_W-1:0] o_n_sym
);

    logic             r_valid;
    logic [SYM_W-1:0] r_sym;
    logic             n_valid;
    logic [SYM_W-1:0] n_sym;
    logic             w_hit;

    // valid as seen after a restart on this beat
    assign o_valid     = r_valid && !i_clear;
    assign o_sym       = r_sym;
    assign w_hit       = i_op.remove && o_valid && (r_sym == i_op.sym);
    assign o_shift_out = i_shift_in || w_hit;

    always_comb begin
        priority if (o_shift_out) begin
            n_valid = i_next_valid;
            n_sym   = i_next_sym;
        end else if (i_op.append && !o_valid && i_prev_valid) begin
            n_valid = 1'b1;
            n_sym   = i_op.sym;
        end else begin
            n_valid = o_valid;
            n_sym   = r_sym;
        end
    end

    assign o_n_valid = n_valid;
    assign o_n_sym   = n_sym;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sym <= n_sym;
        end
    end

endmodule

// File: src/first_unique_symbol_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_unique_symbol_tracker_top
// Reports after every symbol the oldest symbol seen exactly once so far.
// ----------------------------------------------------------------------------
// Result: registered; a beat's result is valid in the cycle after its acceptance.
// Throughput: 1 beat per cycle unless m_axis_tready stalls the output; the
//   removal shift rippling through the row of cells sets the cycle time.
// Reset: synchronous active-low i_rst_n clears the status table, the cell
//   valid bits and the output valid flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module first_unique_symbol_tracker_top
    import fust_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [4:0] letter, [7:5] zero
    input  logic       s_axis_tuser,   // [0] restart
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [4:0] first_unique, [7:5] zero
    output logic       m_axis_tuser    // [0] found
);

    logic             w_accept;
    logic [SYM_W-1:0] w_letter;
    t_list_op         w_op;

    // chain wiring between neighboring cells
    logic             w_valid   [ALPHABET_SIZE];
    logic [SYM_W-1:0] w_sym     [ALPHABET_SIZE];
    logic             w_shift   [ALPHABET_SIZE+1];
    logic             w_n_valid [ALPHABET_SIZE];
    logic [SYM_W-1:0] w_n_sym   [ALPHABET_SIZE];

    logic             r_m_valid;
    logic             r_found;
    logic [SYM_W-1:0] r_first;

    // Take a new beat whenever the output register is empty or drains now.
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_letter      = s_axis_tdata[SYM_W-1:0];

    // Status table: turns each letter into append, remove or nothing.
    fust_status #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_status (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_accept),
        .i_restart (s_axis_tuser),
        .i_letter  (w_letter),
        .o_op      (w_op)
    );

    // Row of list cells, head at index 0. A removal hit starts a shift that
    // runs to the tail, so every cell behind the hit takes its right neighbor
    // and the list stays compacted. An append lands in the first empty cell.
    assign w_shift[0] = 1'b0;

    for (genvar g = 0; g < ALPHABET_SIZE; g++) begin : g_cell
        logic             w_prev_valid;
        logic             w_next_valid;
        logic [SYM_W-1:0] w_next_sym;

        if (g == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == ALPHABET_SIZE - 1) begin : g_tail
            assign w_next_valid = 1'b0;
            assign w_next_sym   = '0;
        end else begin : g_inner
            assign w_next_valid = w_valid[g+1];
            assign w_next_sym   = w_sym[g+1];
        end

        fust_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (w_accept),
            .i_clear      (s_axis_tuser),
            .i_op         (w_op),
            .i_prev_valid (w_prev_valid),
            .i_shift_in   (w_shift[g]),
            .i_next_valid (w_next_valid),
            .i_next_sym   (w_next_sym),
            .o_shift_out  (w_shift[g+1]),
            .o_valid      (w_valid[g]),
            .o_sym        (w_sym[g]),
            .o_n_valid    (w_n_valid[g]),
            .o_n_sym      (w_n_sym[g])
        );
    end

    // Output register: hold the head of the updated list until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_m_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_found <= w_n_valid[0];
            r_first <= w_n_valid[0] ? w_n_sym[0] : '0;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_found;
    assign m_axis_tdata  = {{(8-SYM_W){1'b0}}, r_first};

endmodule
